[sv/hmtt_pkg.sv]
// Shared types, constants and helper functions of the height matched track table.
package hmtt_pkg;

   // Default sizes of the table
   localparam int TRACK_SLOTS_DEF  = 16;
   localparam int CONF_CEILING_DEF = 12;
   localparam int MAX_RESULTS      = 16;

   // Field widths
   localparam int HEIGHT_W   = 16;
   localparam int DIST_W     = 16;
   localparam int TREAD_W    = 15;
   localparam int CONF_W     = 4;
   localparam int SLOT_W     = 4;
   localparam int KIND_W     = 3;
   localparam int TOL_W      = 15;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;
   localparam int STEP_W     = HEIGHT_W + 1;

   // Register reset values
   localparam logic [TOL_W-1:0]  TOL_RESET     = TOL_W'(250);
   localparam logic [CONF_W-1:0] MIN_VIS_RESET = CONF_W'(4);

   typedef enum logic [KIND_W-1:0] {
      KIND_MATCHED = 3'd0,
      KIND_NEW     = 3'd1,
      KIND_DROPPED = 3'd2,
      KIND_VISIBLE = 3'd3,
      KIND_NONE    = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_TOL = 1'b0,
      CSR_MIN_VIS   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SWEEP,
      ST_FLUSH
   } engine_state_type;

   typedef enum logic {
      CMD_DETECT    = 1'b0,
      CMD_FRAME_END = 1'b1
   } cmd_type;

   // One table entry as held in the slot memory
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic signed [DIST_W-1:0]   distance;
      logic [TREAD_W-1:0]         depth;
      logic [TREAD_W-1:0]         width;
      logic [CONF_W-1:0]          confidence;
   } track_type;

   // Input word
   typedef struct packed {
      cmd_type                    cmd;
      logic signed [HEIGHT_W-1:0] height;
      logic signed [DIST_W-1:0]   distance;
      logic [TREAD_W-1:0]         depth;
      logic [TREAD_W-1:0]         width;
   } req_word_type;

   // Result word
   typedef struct packed {
      kind_type                   kind;
      logic [SLOT_W-1:0]          slot;
      logic signed [HEIGHT_W-1:0] track_height;
      logic signed [DIST_W-1:0]   track_distance;
      logic [TREAD_W-1:0]         track_depth;
      logic [TREAD_W-1:0]         track_width;
      logic [CONF_W-1:0]          confidence;
      logic                       last;
   } rsp_word_type;

   // prev + floor((next - prev) / 4)
   function automatic logic signed [STEP_W-1:0] quarter_step(
      input logic signed [STEP_W-1:0] prev,
      input logic signed [STEP_W-1:0] nxt
   );
      logic signed [STEP_W:0] diff;
      logic signed [STEP_W:0] total;
      diff  = (STEP_W+1)'(nxt) - (STEP_W+1)'(prev);
      total = (STEP_W+1)'(prev) + (diff >>> 2);
      return total[STEP_W-1:0];
   endfunction

endpackage

[sv/hmtt_ram.sv]
// Generic simple dual port RAM with one write port and a registered read port.
module hmtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the entry, register the read word; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/hmtt_engine.sv]
// Scan, match, update, decay and report engine around the slot memory.
module hmtt_engine #(
   parameter int TRACK_SLOTS  = hmtt_pkg::TRACK_SLOTS_DEF,
   parameter int CONF_CEILING = hmtt_pkg::CONF_CEILING_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  hmtt_pkg::req_word_type       req_word,
   input  logic [hmtt_pkg::TOL_W-1:0]   match_tolerance,
   input  logic [hmtt_pkg::CONF_W-1:0]  min_visible_confidence,
   output logic                         idle,
   output logic                         res_valid,
   output hmtt_pkg::rsp_word_type       res_word,
   input  logic                         res_ready
);

   import hmtt_pkg::*;

   localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TRACK_SLOTS + 1);
   localparam int RAM_W = $bits(track_type);
   localparam int VIS_W = $clog2(MAX_RESULTS + 1);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TRACK_SLOTS);
   localparam logic [CONF_W:0]   CEIL      = (CONF_W+1)'(CONF_CEILING);
   localparam logic [VIS_W-1:0]  VIS_LIMIT = VIS_W'(MAX_RESULTS);

   // Control state
   engine_state_type        state_ff, state_in;
   logic [TRACK_SLOTS-1:0]  valid_ff, valid_in;
   logic [TRACK_SLOTS-1:0]  matched_ff, matched_in;
   logic [CNT_W-1:0]        rd_cnt_ff, rd_cnt_in;
   logic                    p_vld_ff, p_vld_in;
   logic                    best_vld_ff, best_vld_in;
   logic                    free_vld_ff, free_vld_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [VIS_W-1:0]        vis_cnt_ff, vis_cnt_in;

   // Payload state
   req_word_type            req_ff, req_in;
   logic [IDX_W-1:0]        p_idx_ff, p_idx_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [HEIGHT_W-1:0]     best_dist_ff, best_dist_in;
   track_type               best_trk_ff, best_trk_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   rsp_word_type            pend_ff, pend_in;

   // Memory port
   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   track_type               ram_wdata;
   logic                    ram_re;
   logic [IDX_W-1:0]        ram_raddr;
   logic [RAM_W-1:0]        ram_rdata;
   track_type               rd_trk;

   // Per slot evaluation
   logic                    cur_valid;
   logic                    cur_matched;
   logic                    cur_decays;
   logic                    cur_kill;
   logic [CONF_W-1:0]       conf_after;
   logic                    valid_after;
   logic                    vis;
   logic                    push_needed;
   logic                    advance;
   logic                    rd_more;
   logic                    walk_done;
   logic signed [HEIGHT_W:0] h_diff;
   logic [HEIGHT_W:0]       h_abs;

   // Update of a matched track
   logic signed [STEP_W-1:0] q_h;
   logic signed [STEP_W-1:0] q_d;
   logic signed [STEP_W-1:0] q_dep;
   logic signed [STEP_W-1:0] q_wid;
   logic [CONF_W:0]         conf_up;
   logic [CONF_W:0]         conf_sat;
   track_type               upd_trk;
   track_type               new_trk;

   hmtt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TRACK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_trk = ram_rdata;
   assign idle   = (state_ff == ST_IDLE);

   // Evaluate the slot whose word just came out of memory
   always_comb begin
      cur_valid   = valid_ff[p_idx_ff];
      cur_matched = matched_ff[p_idx_ff];
      cur_decays  = cur_valid && !cur_matched;
      cur_kill    = cur_decays && (rd_trk.confidence <= CONF_W'(1));
      if (cur_kill) begin
         conf_after = '0;
      end else if (cur_decays) begin
         conf_after = rd_trk.confidence - CONF_W'(1);
      end else begin
         conf_after = rd_trk.confidence;
      end
      valid_after = cur_valid && !cur_kill;
      vis         = valid_after && (conf_after >= min_visible_confidence)
                    && (vis_cnt_ff < VIS_LIMIT);
      push_needed = vis && pend_vld_ff;
      advance     = !(p_vld_ff && push_needed && !res_ready);
      rd_more     = (rd_cnt_ff != LAST_CNT);
      walk_done   = !rd_more && p_vld_ff;
      h_diff      = (HEIGHT_W+1)'(rd_trk.height) - (HEIGHT_W+1)'(req_ff.height);
      h_abs       = h_diff[HEIGHT_W] ? (HEIGHT_W+1)'(-h_diff) : (HEIGHT_W+1)'(h_diff);
   end

   // Build the moved and the seeded track
   always_comb begin
      q_h      = quarter_step(STEP_W'(best_trk_ff.height), STEP_W'(req_ff.height));
      q_d      = quarter_step(STEP_W'(best_trk_ff.distance), STEP_W'(req_ff.distance));
      q_dep    = quarter_step(STEP_W'(best_trk_ff.depth), STEP_W'(req_ff.depth));
      q_wid    = quarter_step(STEP_W'(best_trk_ff.width), STEP_W'(req_ff.width));
      conf_up  = (CONF_W+1)'(best_trk_ff.confidence) + (CONF_W+1)'(2);
      conf_sat = (conf_up > CEIL) ? CEIL : conf_up;
      upd_trk.height     = q_h[HEIGHT_W-1:0];
      upd_trk.distance   = q_d[DIST_W-1:0];
      upd_trk.depth      = q_dep[TREAD_W-1:0];
      upd_trk.width      = q_wid[TREAD_W-1:0];
      upd_trk.confidence = conf_sat[CONF_W-1:0];
      new_trk.height     = req_ff.height;
      new_trk.distance   = req_ff.distance;
      new_trk.depth      = req_ff.depth;
      new_trk.width      = req_ff.width;
      new_trk.confidence = CONF_W'(1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_word.cmd == CMD_FRAME_END) ? ST_SWEEP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (walk_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (walk_done && advance) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory accesses and result word
   always_comb begin
      valid_in     = valid_ff;
      matched_in   = matched_ff;
      rd_cnt_in    = rd_cnt_ff;
      p_vld_in     = p_vld_ff;
      p_idx_in     = p_idx_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      best_trk_in  = best_trk_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      vis_cnt_in   = vis_cnt_ff;
      req_in       = req_ff;
      ram_we       = 1'b0;
      ram_waddr    = p_idx_ff;
      ram_wdata    = rd_trk;
      ram_re       = 1'b0;
      ram_raddr    = rd_cnt_ff[IDX_W-1:0];
      res_valid    = 1'b0;
      res_word     = '0;
      case (state_ff)
         ST_IDLE: begin
            // Take the word and arm the walk
            if (start) begin
               req_in       = req_word;
               rd_cnt_in    = '0;
               p_vld_in     = 1'b0;
               best_vld_in  = 1'b0;
               best_dist_in = HEIGHT_W'(match_tolerance);
               free_vld_in  = 1'b0;
               pend_vld_in  = 1'b0;
               vis_cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            // Issue the next read
            ram_re    = rd_more;
            p_vld_in  = rd_more;
            p_idx_in  = rd_cnt_ff[IDX_W-1:0];
            if (rd_more) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            // Track the lowest free slot and the closest open match
            if (p_vld_ff) begin
               if (!cur_valid) begin
                  if (!free_vld_ff) begin
                     free_vld_in = 1'b1;
                     free_idx_in = p_idx_ff;
                  end
               end else if (!cur_matched && (h_abs[HEIGHT_W-1:0] < best_dist_ff)) begin
                  best_vld_in  = 1'b1;
                  best_idx_in  = p_idx_ff;
                  best_dist_in = h_abs[HEIGHT_W-1:0];
                  best_trk_in  = rd_trk;
               end
            end
         end
         ST_UPDATE: begin
            res_valid = 1'b1;
            res_word.last = 1'b1;
            if (best_vld_ff) begin
               res_word.kind           = KIND_MATCHED;
               res_word.slot           = SLOT_W'(best_idx_ff);
               res_word.track_height   = upd_trk.height;
               res_word.track_distance = upd_trk.distance;
               res_word.track_depth    = upd_trk.depth;
               res_word.track_width    = upd_trk.width;
               res_word.confidence     = upd_trk.confidence;
               ram_waddr = best_idx_ff;
               ram_wdata = upd_trk;
               if (res_ready) begin
                  ram_we                  = 1'b1;
                  matched_in[best_idx_ff] = 1'b1;
               end
            end else if (free_vld_ff) begin
               res_word.kind           = KIND_NEW;
               res_word.slot           = SLOT_W'(free_idx_ff);
               res_word.track_height   = new_trk.height;
               res_word.track_distance = new_trk.distance;
               res_word.track_depth    = new_trk.depth;
               res_word.track_width    = new_trk.width;
               res_word.confidence     = new_trk.confidence;
               ram_waddr = free_idx_ff;
               ram_wdata = new_trk;
               if (res_ready) begin
                  ram_we                  = 1'b1;
                  valid_in[free_idx_ff]   = 1'b1;
                  matched_in[free_idx_ff] = 1'b1;
               end
            end else begin
               // Table full: echo the detection
               res_word.kind           = KIND_DROPPED;
               res_word.track_height   = req_ff.height;
               res_word.track_distance = req_ff.distance;
               res_word.track_depth    = req_ff.depth;
               res_word.track_width    = req_ff.width;
            end
         end
         ST_SWEEP: begin
            if (advance) begin
               // Issue the next read
               ram_re   = rd_more;
               p_vld_in = rd_more;
               p_idx_in = rd_cnt_ff[IDX_W-1:0];
               if (rd_more) begin
                  rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               end
               // Decay, free, clear the mark, stage a visible track
               if (p_vld_ff) begin
                  valid_in[p_idx_ff]   = valid_after;
                  matched_in[p_idx_ff] = 1'b0;
                  if (cur_decays) begin
                     ram_we               = 1'b1;
                     ram_wdata.confidence = conf_after;
                  end
                  if (vis) begin
                     vis_cnt_in             = vis_cnt_ff + VIS_W'(1);
                     pend_vld_in            = 1'b1;
                     pend_in.kind           = KIND_VISIBLE;
                     pend_in.slot           = SLOT_W'(p_idx_ff);
                     pend_in.track_height   = rd_trk.height;
                     pend_in.track_distance = rd_trk.distance;
                     pend_in.track_depth    = rd_trk.depth;
                     pend_in.track_width    = rd_trk.width;
                     pend_in.confidence     = conf_after;
                     pend_in.last           = 1'b0;
                     if (pend_vld_ff) begin
                        res_valid = 1'b1;
                        res_word  = pend_ff;
                     end
                  end
               end
            end
         end
         ST_FLUSH: begin
            // Send the held visible track as the last word, or the empty report
            res_valid = 1'b1;
            if (pend_vld_ff) begin
               res_word      = pend_ff;
               res_word.last = 1'b1;
            end else begin
               res_word.kind = KIND_NONE;
               res_word.last = 1'b1;
            end
            if (res_ready) begin
               pend_vld_in = 1'b0;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         matched_ff  <= '0;
         rd_cnt_ff   <= '0;
         p_vld_ff    <= 1'b0;
         best_vld_ff <= 1'b0;
         free_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         vis_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         matched_ff  <= matched_in;
         rd_cnt_ff   <= rd_cnt_in;
         p_vld_ff    <= p_vld_in;
         best_vld_ff <= best_vld_in;
         free_vld_ff <= free_vld_in;
         pend_vld_ff <= pend_vld_in;
         vis_cnt_ff  <= vis_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      p_idx_ff     <= p_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      best_trk_ff  <= best_trk_in;
      free_idx_ff  <= free_idx_in;
      pend_ff      <= pend_in;
   end

endmodule

[sv/height_matched_track_table.sv]
// Top level of the height matched track table: registers, engine and result register.
//
// The block holds up to TRACK_SLOTS plane tracks in one slot memory and walks that
// memory one slot per cycle for every input word, except while an end of frame walk
// waits on a full, stalled output register. A detection word goes from acceptance
// to the next acceptance through these steps: the idle state takes the word, the
// read walk visits each slot, the memory read delivers the last slot word, and the
// update state writes back the matched or seeded track once the output register
// can take the result. An end of frame word walks the memory the same way, decaying,
// freeing and reporting visible tracks in slot order, and waits whenever the output
// register stays full and stalled while a visible track or the final report waits
// to be handed over. Only one input word is in work at a time;
// a finished result waits in the output register while the next word is taken.
// The table is empty right after reset; the tolerance and visibility registers
// must be written only while the block is idle.
module height_matched_track_table #(
   parameter int TRACK_SLOTS  = hmtt_pkg::TRACK_SLOTS_DEF,
   parameter int CONF_CEILING = hmtt_pkg::CONF_CEILING_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [hmtt_pkg::HEIGHT_W-1:0] req_height,
   input  logic signed [hmtt_pkg::DIST_W-1:0]   req_distance,
   input  logic [hmtt_pkg::TREAD_W-1:0]        req_depth,
   input  logic [hmtt_pkg::TREAD_W-1:0]        req_width,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hmtt_pkg::kind_type                  rsp_kind,
   output logic [hmtt_pkg::SLOT_W-1:0]         rsp_slot,
   output logic signed [hmtt_pkg::HEIGHT_W-1:0] rsp_track_height,
   output logic signed [hmtt_pkg::DIST_W-1:0]   rsp_track_distance,
   output logic [hmtt_pkg::TREAD_W-1:0]        rsp_track_depth,
   output logic [hmtt_pkg::TREAD_W-1:0]        rsp_track_width,
   output logic [hmtt_pkg::CONF_W-1:0]         rsp_confidence,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [hmtt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hmtt_pkg::CSR_DATA_W-1:0]     csr_data
);

   import hmtt_pkg::*;

   logic [TOL_W-1:0]   tol_ff, tol_in;
   logic [CONF_W-1:0]  min_vis_ff, min_vis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               eng_idle;
   logic               start;
   req_word_type       req_word;
   logic               res_valid;
   rsp_word_type       res_word;
   logic               res_ready;

   // Gather the input word
   always_comb begin
      req_word.cmd      = cmd_type'(req_cmd);
      req_word.height   = req_height;
      req_word.distance = req_distance;
      req_word.depth    = req_depth;
      req_word.width    = req_width;
   end

   assign req_stall = !eng_idle;
   assign start     = req_valid && eng_idle;

   // Register writes
   always_comb begin
      tol_in     = tol_ff;
      min_vis_in = min_vis_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MATCH_TOL: tol_in     = csr_data[TOL_W-1:0];
            CSR_MIN_VIS:   min_vis_in = csr_data[CONF_W-1:0];
            default:       tol_in     = tol_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= TOL_RESET;
         min_vis_ff <= MIN_VIS_RESET;
      end else begin
         tol_ff     <= tol_in;
         min_vis_ff <= min_vis_in;
      end
   end

   hmtt_engine #(
      .TRACK_SLOTS  (TRACK_SLOTS),
      .CONF_CEILING (CONF_CEILING)
   ) u_engine (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .req_word               (req_word),
      .match_tolerance        (tol_ff),
      .min_visible_confidence (min_vis_ff),
      .idle                   (eng_idle),
      .res_valid              (res_valid),
      .res_word               (res_word),
      .res_ready              (res_ready)
   );

   // Output register: load when empty or when the held word leaves
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_word_in = res_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_word_ff.kind;
   assign rsp_slot           = rsp_word_ff.slot;
   assign rsp_track_height   = rsp_word_ff.track_height;
   assign rsp_track_distance = rsp_word_ff.track_distance;
   assign rsp_track_depth    = rsp_word_ff.track_depth;
   assign rsp_track_width    = rsp_word_ff.track_width;
   assign rsp_confidence     = rsp_word_ff.confidence;
   assign rsp_last           = rsp_word_ff.last;

endmodule

[sv/hmtt_checker.sv]
// Port level checks of the height matched track table, bound to the top level.
module hmtt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input hmtt_pkg::kind_type          rsp_kind,
   input logic [hmtt_pkg::SLOT_W-1:0] rsp_slot,
   input logic [hmtt_pkg::CONF_W-1:0] rsp_confidence,
   input logic                        rsp_last
);

   import hmtt_pkg::*;

   // No result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // One word in work at a time: the input side stalls after each accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a word is in work");

   // A detection result always carries the last flag
   a_detect_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_MATCHED || rsp_kind == KIND_NEW ||
                    rsp_kind == KIND_DROPPED) |-> rsp_last)
      else $error("detection result without last");

   // Empty report carries no slot and no confidence
   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NONE |->
         rsp_slot == '0 && rsp_confidence == '0 && rsp_last)
      else $error("empty report carries data");

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot))
      else $error("stalled result word changed");

endmodule

bind height_matched_track_table hmtt_checker u_hmtt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_slot       (rsp_slot),
   .rsp_confidence (rsp_confidence),
   .rsp_last       (rsp_last)
);

[sim/height_matched_track_table_test.sv]
// Self-checking testbench of the height matched track table with random handshake pressure.
module height_matched_track_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hmtt_pkg::*;

   localparam int SLOT_COUNT    = TRACK_SLOTS_DEF;
   localparam int CONF_TOP      = CONF_CEILING_DEF;
   localparam int SETTLE_CYCLES = SLOT_COUNT + 8;
   localparam int CYCLE_LIMIT   = 1000000;

   // Predicts the result words of the track table and checks the ones seen
   class track_table_predictor;
      bit                         slot_live [SLOT_COUNT];
      bit                         slot_claimed [SLOT_COUNT];
      logic signed [HEIGHT_W-1:0] trk_height [SLOT_COUNT];
      logic signed [DIST_W-1:0]   trk_distance [SLOT_COUNT];
      logic [TREAD_W-1:0]         trk_depth [SLOT_COUNT];
      logic [TREAD_W-1:0]         trk_width [SLOT_COUNT];
      logic [CONF_W-1:0]          trk_conf [SLOT_COUNT];
      logic [TOL_W-1:0]           tolerance;
      logic [CONF_W-1:0]          min_visible;
      rsp_word_type               awaited_responses [$];
      int                         errors;

      function new();
         tolerance   = TOL_RESET;
         min_visible = MIN_VIS_RESET;
         errors      = 0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_live[i]    = 1'b0;
            slot_claimed[i] = 1'b0;
         end
      endfunction

      function void write_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_MATCH_TOL: tolerance = value[TOL_W-1:0];
            CSR_MIN_VIS:   min_visible = value[CONF_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction

      // Move a quarter of the way toward the target, rounding toward minus infinity
      function int approach(int prev, int target);
         int gap;
         gap = target - prev;
         return prev + (gap >>> 2);
      endfunction

      function void queue_response(kind_type kind, int slot, int h, int fwd, int dep,
                                   int wid, int conf, bit last);
         rsp_word_type word;
         word.kind           = kind;
         word.slot           = SLOT_W'(slot);
         word.track_height   = HEIGHT_W'(h);
         word.track_distance = DIST_W'(fwd);
         word.track_depth    = TREAD_W'(dep);
         word.track_width    = TREAD_W'(wid);
         word.confidence     = CONF_W'(conf);
         word.last           = last;
         awaited_responses.insert(awaited_responses.size(), word);
      endfunction

      function void accept_request(req_word_type word);
         int h, fwd, dep, wid, gap, best_slot, best_gap, free_slot, conf;
         int shown [$];
         if (word.cmd == CMD_DETECT) begin
            h         = $signed(word.height);
            fwd       = $signed(word.distance);
            dep       = word.depth;
            wid       = word.width;
            best_slot = -1;
            best_gap  = tolerance;
            free_slot = -1;
            // find the closest unclaimed track inside the window, lowest slot on ties
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!slot_live[i]) begin
                  if (free_slot < 0) free_slot = i;
               end else if (!slot_claimed[i]) begin
                  gap = int'(trk_height[i]) - h;
                  if (gap < 0) gap = -gap;
                  if (gap < best_gap) begin
                     best_gap  = gap;
                     best_slot = i;
                  end
               end
            end
            if (best_slot >= 0) begin
               conf = trk_conf[best_slot] + 2;
               if (conf > CONF_TOP) conf = CONF_TOP;
               trk_height[best_slot]   = HEIGHT_W'(approach(trk_height[best_slot], h));
               trk_distance[best_slot] = DIST_W'(approach(trk_distance[best_slot], fwd));
               trk_depth[best_slot]    = TREAD_W'(approach(trk_depth[best_slot], dep));
               trk_width[best_slot]    = TREAD_W'(approach(trk_width[best_slot], wid));
               trk_conf[best_slot]     = CONF_W'(conf);
               slot_claimed[best_slot] = 1'b1;
               queue_response(KIND_MATCHED, best_slot, trk_height[best_slot],
                              trk_distance[best_slot], trk_depth[best_slot],
                              trk_width[best_slot], conf, 1'b1);
            end else if (free_slot >= 0) begin
               slot_live[free_slot]    = 1'b1;
               slot_claimed[free_slot] = 1'b1;
               trk_height[free_slot]   = word.height;
               trk_distance[free_slot] = word.distance;
               trk_depth[free_slot]    = word.depth;
               trk_width[free_slot]    = word.width;
               trk_conf[free_slot]     = CONF_W'(1);
               queue_response(KIND_NEW, free_slot, h, fwd, dep, wid, 1, 1'b1);
            end else begin
               queue_response(KIND_DROPPED, 0, h, fwd, dep, wid, 0, 1'b1);
            end
         end else begin
            // decay and free unmatched tracks, then clear the match marks
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_live[i] && !slot_claimed[i]) begin
                  if (trk_conf[i] <= 1) begin
                     slot_live[i] = 1'b0;
                     trk_conf[i]  = '0;
                  end else begin
                     trk_conf[i] = trk_conf[i] - 1'b1;
                  end
               end
               slot_claimed[i] = 1'b0;
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_live[i] && trk_conf[i] >= min_visible && shown.size() < MAX_RESULTS)
                  shown.insert(shown.size(), i);
            end
            if (shown.size() == 0) begin
               queue_response(KIND_NONE, 0, 0, 0, 0, 0, 0, 1'b1);
            end else begin
               foreach (shown[k]) begin
                  queue_response(KIND_VISIBLE, shown[k], trk_height[shown[k]],
                                 trk_distance[shown[k]], trk_depth[shown[k]],
                                 trk_width[shown[k]], trk_conf[shown[k]],
                                 k == shown.size() - 1);
               end
            end
         end
      endfunction

      function void check_field(string name, logic signed [31:0] want,
                                logic signed [31:0] seen);
         if (want !== seen) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (awaited_responses.size() == 0) begin
            $error("result word with no request waiting: kind %0d slot %0d",
                   got.kind, got.slot);
            errors++;
            return;
         end
         want = awaited_responses.pop_front();
         check_field("kind", want.kind, got.kind);
         check_field("slot", want.slot, got.slot);
         check_field("track_height", $signed(want.track_height), $signed(got.track_height));
         check_field("track_distance", $signed(want.track_distance),
                     $signed(got.track_distance));
         check_field("track_depth", want.track_depth, got.track_depth);
         check_field("track_width", want.track_width, got.track_width);
         check_field("confidence", want.confidence, got.confidence);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_cmd;
   logic signed [HEIGHT_W-1:0] req_height;
   logic signed [DIST_W-1:0]   req_distance;
   logic [TREAD_W-1:0]         req_depth;
   logic [TREAD_W-1:0]         req_width;
   logic                       rsp_valid;
   logic                       rsp_stall;
   kind_type                   rsp_kind;
   logic [SLOT_W-1:0]          rsp_slot;
   logic signed [HEIGHT_W-1:0] rsp_track_height;
   logic signed [DIST_W-1:0]   rsp_track_distance;
   logic [TREAD_W-1:0]         rsp_track_depth;
   logic [TREAD_W-1:0]         rsp_track_width;
   logic [CONF_W-1:0]          rsp_confidence;
   logic                       rsp_last;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   track_table_predictor tracker;
   int                   hold_off_request = 0;
   int                   cycle_count = 0;

   height_matched_track_table DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_height         (req_height),
      .req_distance       (req_distance),
      .req_depth          (req_depth),
      .req_width          (req_width),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_slot           (rsp_slot),
      .rsp_track_height   (rsp_track_height),
      .rsp_track_distance (rsp_track_distance),
      .rsp_track_depth    (rsp_track_depth),
      .rsp_track_width    (rsp_track_width),
      .rsp_confidence     (rsp_confidence),
      .rsp_last           (rsp_last),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Check every result word taken from the block
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind           = rsp_kind;
         got.slot           = rsp_slot;
         got.track_height   = rsp_track_height;
         got.track_distance = rsp_track_distance;
         got.track_depth    = rsp_track_depth;
         got.track_width    = rsp_track_width;
         got.confidence     = rsp_confidence;
         got.last           = rsp_last;
         tracker.check_response(got);
      end
   end

   // Result side: alternate open and stalled runs, honor a requested long hold-off
   initial begin
      int hold_left;
      int run_left;
      bit stalling;
      hold_left = 0;
      run_left  = 0;
      stalling  = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            stalling = 1'b1;
            run_left = 0;
            rsp_stall <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            stalling = !stalling && ($urandom_range(0, 3) != 0);
            if (stalling)
               run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(0, 2);
            else
               run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 5);
            rsp_stall <= stalling;
         end
      end
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic int rand_signed();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int jitter(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic req_word_type detection(int h, int fwd, int dep, int wid);
      req_word_type word;
      word.cmd      = CMD_DETECT;
      word.height   = HEIGHT_W'(h);
      word.distance = DIST_W'(fwd);
      word.depth    = TREAD_W'(dep);
      word.width    = TREAD_W'(wid);
      return word;
   endfunction

   function automatic req_word_type noise_detection();
      return detection(rand_signed(), rand_signed(), $urandom_range(0, 32767),
                       $urandom_range(0, 32767));
   endfunction

   // Payload bits other than the command are don't-care on a frame end
   function automatic req_word_type frame_end();
      req_word_type word;
      word     = noise_detection();
      word.cmd = CMD_FRAME_END;
      return word;
   endfunction

   // Offer one word after a gap and hold it until the block takes it
   task automatic send_word(req_word_type word, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= word.cmd;
      req_height   <= word.height;
      req_distance <= word.distance;
      req_depth    <= word.depth;
      req_width    <= word.width;
      do @(posedge clock); while (req_stall);
      tracker.accept_request(word);
   endtask

   // Stop offering and wait for every awaited result plus the engine's tail
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back while the block is idle
   task automatic configure(logic [CSR_DATA_W-1:0] tol_value,
                            logic [CSR_DATA_W-1:0] vis_value);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_MATCH_TOL;
      csr_data  <= tol_value;
      @(posedge clock);
      tracker.write_register(CSR_MATCH_TOL, tol_value);
      csr_index <= CSR_MIN_VIS;
      csr_data  <= vis_value;
      @(posedge clock);
      tracker.write_register(CSR_MIN_VIS, vis_value);
      csr_write <= 1'b0;
   endtask

   // Frames of a staircase: steady planes seen with jitter, some misses, some clutter
   task automatic run_frames(int frames, int planes, int spread, int noise_pct);
      int plane_h [6];
      int plane_d [6];
      int plane_dep [6];
      int plane_wid [6];
      int base;
      int spacing;
      base    = int'($urandom_range(0, 50000)) - 32768;
      spacing = 2 * spread + $urandom_range(50, 1500);
      for (int p = 0; p < planes; p++) begin
         plane_h[p]   = clamp(base + p * spacing, -32768, 32767);
         plane_d[p]   = rand_signed();
         plane_dep[p] = $urandom_range(0, 32767);
         plane_wid[p] = $urandom_range(0, 32767);
      end
      for (int f = 0; f < frames; f++) begin
         for (int p = 0; p < planes; p++) begin
            if ($urandom_range(0, 99) < 85)
               send_word(detection(clamp(plane_h[p] + jitter(spread), -32768, 32767),
                                   clamp(plane_d[p] + jitter(300), -32768, 32767),
                                   clamp(plane_dep[p] + jitter(300), 0, 32767),
                                   clamp(plane_wid[p] + jitter(300), 0, 32767)),
                         sender_gap());
            if ($urandom_range(0, 99) < noise_pct)
               send_word(noise_detection(), sender_gap());
         end
         send_word(frame_end(), sender_gap());
      end
   endtask

   initial begin
      tracker = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= CMD_DETECT;
      req_height   <= '0;
      req_distance <= '0;
      req_depth    <= '0;
      req_width    <= '0;
      csr_write    <= 1'b0;
      csr_index    <= CSR_MATCH_TOL;
      csr_data     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset register values, back to back
      send_word(frame_end(), 0);
      send_word(detection(32767, -32768, 32767, 0), 0);
      send_word(detection(-32768, 32767, 0, 32767), 0);
      send_word(detection(1000, 500, 100, 200), 0);
      send_word(detection(1100, 400, 300, 100), 0);       // near a track already matched
      send_word(frame_end(), 0);
      send_word(detection(-32518, 0, 32767, 32767), 0);   // exactly at the window edge
      send_word(detection(1050, 600, 150, 250), 0);       // equal distance to two tracks
      send_word(detection(32767, 32767, 0, 32767), 0);
      send_word(detection(-32768, -32768, 32767, 0), 0);
      send_word(detection(1049, 0, 0, 0), 0);
      send_word(frame_end(), 0);
      send_word(detection(32767, -32768, 32767, 0), 0);
      send_word(detection(-32768, 32767, 0, 32767), 0);
      send_word(frame_end(), 0);                          // frees a track at one
      send_word(detection(-3, -7, 5, 3), 0);
      send_word(detection(-1, -1, 1, 1), 0);
      send_word(frame_end(), 0);
      send_word(detection(-6, -9, 2, 0), 0);              // negative steps round down
      send_word(detection(0, 0, 0, 0), 0);
      send_word(frame_end(), 0);

      // Tracked staircase while the result side holds off for a long stretch
      configure(CSR_DATA_W'(300), CSR_DATA_W'(3));
      hold_off_request = 300;
      run_frames(8, 4, 200, 20);

      // Zero window: fill the table, drop the overflow, then let everything decay
      configure('0, {(CSR_DATA_W-CONF_W)'($urandom_range(0, 2047)), 4'd1});
      for (int i = 0; i < 20; i++) send_word(noise_detection(), sender_gap());
      send_word(frame_end(), sender_gap());
      for (int i = 0; i < 3; i++) send_word(noise_detection(), sender_gap());
      drain();
      send_word(frame_end(), sender_gap());
      send_word(frame_end(), sender_gap());

      // Widest window and highest visibility threshold the confidence can reach
      configure(CSR_DATA_W'(32767), CSR_DATA_W'(CONF_TOP));
      run_frames(7, 3, 400, 10);

      // Random window, every live track visible
      configure(CSR_DATA_W'($urandom_range(1, 2000)),
                {(CSR_DATA_W-CONF_W)'($urandom_range(0, 2047)), 4'd0});
      run_frames(6, 4, 150, 25);

      // Clutter only, threshold above the ceiling
      configure(CSR_DATA_W'($urandom_range(0, 32767)), CSR_DATA_W'(15));
      for (int i = 0; i < 20; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_word(frame_end(), sender_gap());
         else
            send_word(noise_detection(), sender_gap());
      end
      send_word(frame_end(), sender_gap());

      drain();
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
